>>> rtl/lpht_pkg.sv
// lpht_pkg: shared types, codes and default sizes for the linear probe hash table
// no dependencies; used by lpht_rem, the core and the bench
package lpht_pkg;

	// default sizes
	localparam int DEPTH_DEF      = 1024;
	localparam int VALUE_BITS_DEF = 32;
	localparam int KEY_BITS       = 64;
	localparam int TS_W           = 11;
	localparam int TS_RESET       = 1024;
	localparam int FOUND_W        = 32;
	localparam int LIVE_W         = 11;

	// operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_FIND   = 2'd1;
	localparam logic [1:0] OP_ERASE  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DUP  = 2'd1;
	localparam logic [1:0] ST_MISS = 2'd2;

	// slot state codes
	localparam logic [1:0] SLOT_FREE = 2'd0;
	localparam logic [1:0] SLOT_OCC  = 2'd1;
	localparam logic [1:0] SLOT_DEL  = 2'd2;

	// configuration register index
	localparam logic REG_TABLE_SIZE = 1'b0;

	typedef struct packed {
		logic [1:0]          op;
		logic [KEY_BITS-1:0] key;
		logic [31:0]         value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [FOUND_W-1:0] found_value;
		logic [LIVE_W-1:0]  live_count;
	} res_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_READ,
		S_CHECK
	} fsm_t;

	// decisions taken on one probed slot
	typedef struct packed {
		logic       finish;
		logic       advance;
		logic [1:0] status;
		logic       use_value;
		logic       cnt_inc;
		logic       cnt_dec;
	} probe_ctl_t;

endpackage

>>> rtl/lpht_ram.sv
// lpht_ram: generic single write port, single read port ram with registered read
// no dependencies
module lpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/lpht_rem.sv
// lpht_rem: bit-serial remainder of the 64-bit key by the table size
// depends on lpht_pkg for the key width
module lpht_rem #(
	parameter int DEPTH = lpht_pkg::DEPTH_DEF,
	localparam int IDX_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lpht_pkg::KEY_BITS-1:0] dividend,
	input  logic [CNT_W-1:0]              divisor,
	output logic                          busy,
	output logic [IDX_W-1:0]              rem
);

	localparam int STEP_W = $clog2(lpht_pkg::KEY_BITS);

	logic                          busy_q;
	logic [STEP_W-1:0]             step_q;
	logic [CNT_W-1:0]              rem_q;
	logic [CNT_W-1:0]              div_q;
	logic [lpht_pkg::KEY_BITS-1:0] dvd_q;
	logic [CNT_W:0]                shifted;
	logic [CNT_W:0]                trial;

	// one restoring step per cycle
	always_comb begin
		shifted = {rem_q, dvd_q[lpht_pkg::KEY_BITS-1]};
		trial   = shifted - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(lpht_pkg::KEY_BITS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= (shifted >= {1'b0, div_q}) ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
			dvd_q <= dvd_q << 1;
		end
	end

	assign busy = busy_q;
	// remainder is below the divisor, which is at most DEPTH
	assign rem  = rem_q[IDX_W-1:0];

endmodule

>>> rtl/linear_probe_hash_table_core.sv
// linear_probe_hash_table_core: top level, sequencer, config port and slot stores
// depends on lpht_pkg, lpht_ram and lpht_rem
//
// channel   | signals                                  | transfer
// ----------+------------------------------------------+-----------------------------
// command   | start, busy, cmd (op, key, value)        | start high while busy low
// result    | done, result (status, value, live count) | done high, one cycle, no stall
// config    | psel, penable, pwrite, paddr, pwdata ... | access phase, pready always 1
//
// after reset a clearing pass marks all DEPTH slots free, busy high
// busy stays high while lpht_rem works out the key remainder (a load, then 64 steps)
// then each probed slot passes S_READ (ram read) and S_CHECK (compare), up to table_size slots
// invalid op answers the cycle after the transfer; done pulses as busy falls
// the result port has no stall: done marks the single cycle the result is valid
module linear_probe_hash_table_core #(
	parameter int DEPTH      = lpht_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  lpht_pkg::cmd_t cmd,
	output logic           done,
	output lpht_pkg::res_t result,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int KW    = lpht_pkg::KEY_BITS;

	lpht_pkg::fsm_t       state_q, state_d;
	lpht_pkg::probe_ctl_t ctl;

	logic [lpht_pkg::TS_W-1:0] ts_q;
	logic [CNT_W-1:0]          n_eff;
	logic [CNT_W-1:0]          n_q;
	logic [1:0]                op_q;
	logic [KW-1:0]             key_q;
	logic [VALUE_BITS-1:0]     val_q;
	logic [IDX_W-1:0]          idx_q;
	logic [IDX_W-1:0]          idx_next;
	logic [CNT_W-1:0]          probe_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          count_d;
	logic [IDX_W-1:0]          clr_q;
	logic                      done_q;
	lpht_pkg::res_t            res_q;

	logic                      accept;
	logic                      bad_op;
	logic                      rem_start;
	logic                      rem_busy;
	logic [IDX_W-1:0]          rem_idx;

	logic                      st_we;
	logic [IDX_W-1:0]          st_waddr;
	logic [1:0]                st_wdata;
	logic [1:0]                st_rd;
	logic                      kv_we;
	logic [KW-1:0]             key_rd;
	logic [VALUE_BITS-1:0]     val_rd;
	logic                      slot_occ;
	logic                      match;
	logic                      last;

	// config port
	logic cfg_we;
	assign cfg_we = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q <= lpht_pkg::TS_W'(lpht_pkg::TS_RESET);
		end else if (cfg_we && paddr[2] == lpht_pkg::REG_TABLE_SIZE) begin
			ts_q <= pwdata[lpht_pkg::TS_W-1:0];
		end
	end

	assign prdata = (paddr[2] == lpht_pkg::REG_TABLE_SIZE) ?
		32'(ts_q) : 32'd0;

	// effective table size: zero acts as one, clamp at DEPTH
	always_comb begin
		if (ts_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (32'(ts_q) > 32'(DEPTH)) begin
			n_eff = CNT_W'(DEPTH);
		end else begin
			n_eff = CNT_W'(ts_q);
		end
	end

	assign accept = start && !busy;
	assign bad_op = !(cmd.op == lpht_pkg::OP_INSERT || cmd.op == lpht_pkg::OP_FIND ||
		cmd.op == lpht_pkg::OP_ERASE);
	assign rem_start = accept && !bad_op;

	lpht_rem #(.DEPTH(DEPTH)) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (cmd.key),
		.divisor  (n_eff),
		.busy     (rem_busy),
		.rem      (rem_idx)
	);

	// slot stores, read at the current probe index
	lpht_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_state_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (idx_q),
		.rdata (st_rd)
	);

	lpht_ram #(.WIDTH(KW), .DEPTH(DEPTH)) u_key_ram (
		.clk   (clk),
		.we    (kv_we),
		.waddr (idx_q),
		.wdata (key_q),
		.raddr (idx_q),
		.rdata (key_rd)
	);

	lpht_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_value_ram (
		.clk   (clk),
		.we    (kv_we),
		.waddr (idx_q),
		.wdata (val_q),
		.raddr (idx_q),
		.rdata (val_rd)
	);

	// slot compare
	assign slot_occ = (st_rd == lpht_pkg::SLOT_OCC);
	assign match    = slot_occ && (key_rd == key_q);
	assign last     = ((probe_q + 1'b1) == n_q);
	assign idx_next = (({1'b0, idx_q} + 1'b1) == (IDX_W + 1)'(n_q)) ? '0 : idx_q + 1'b1;

	// probe decisions and store writes
	always_comb begin
		ctl      = '0;
		ctl.status = lpht_pkg::ST_MISS;
		st_we    = 1'b0;
		st_waddr = idx_q;
		st_wdata = lpht_pkg::SLOT_OCC;
		kv_we    = 1'b0;
		unique case (state_q)
			lpht_pkg::S_CLEAR: begin
				st_we    = 1'b1;
				st_waddr = clr_q;
				st_wdata = lpht_pkg::SLOT_FREE;
			end
			lpht_pkg::S_IDLE: begin
				ctl.finish = accept && bad_op;
			end
			lpht_pkg::S_HASH, lpht_pkg::S_READ: begin
			end
			lpht_pkg::S_CHECK: begin
				if (op_q == lpht_pkg::OP_INSERT) begin
					if (match) begin
						ctl.finish = 1'b1;
						ctl.status = lpht_pkg::ST_DUP;
					end else if (!slot_occ) begin
						ctl.finish  = 1'b1;
						ctl.status  = lpht_pkg::ST_OK;
						ctl.cnt_inc = 1'b1;
						st_we       = 1'b1;
						kv_we       = 1'b1;
					end else if (last) begin
						ctl.finish = 1'b1;
					end else begin
						ctl.advance = 1'b1;
					end
				end else begin
					if (match) begin
						ctl.finish = 1'b1;
						ctl.status = lpht_pkg::ST_OK;
						if (op_q == lpht_pkg::OP_FIND) begin
							ctl.use_value = 1'b1;
						end else begin
							ctl.cnt_dec = 1'b1;
							st_we       = 1'b1;
							st_wdata    = lpht_pkg::SLOT_DEL;
						end
					end else if (last) begin
						ctl.finish = 1'b1;
					end else begin
						ctl.advance = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lpht_pkg::S_CLEAR: begin
				if (clr_q == IDX_W'(DEPTH - 1)) state_d = lpht_pkg::S_IDLE;
			end
			lpht_pkg::S_IDLE: begin
				if (rem_start) state_d = lpht_pkg::S_HASH;
			end
			lpht_pkg::S_HASH: begin
				if (!rem_busy) state_d = lpht_pkg::S_READ;
			end
			lpht_pkg::S_READ: begin
				state_d = lpht_pkg::S_CHECK;
			end
			lpht_pkg::S_CHECK: begin
				state_d = ctl.finish ? lpht_pkg::S_IDLE : lpht_pkg::S_READ;
			end
			default: begin
				state_d = lpht_pkg::S_IDLE;
			end
		endcase
	end

	// live count after this operation
	always_comb begin
		count_d = count_q;
		if (ctl.cnt_inc) begin
			count_d = count_q + 1'b1;
		end else if (ctl.cnt_dec && count_q != '0) begin
			count_d = count_q - 1'b1;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpht_pkg::S_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= ctl.finish;
			if (state_q == lpht_pkg::S_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

	// operation and probe registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= cmd.op;
			key_q <= cmd.key;
			val_q <= VALUE_BITS'(cmd.value);
			n_q   <= n_eff;
		end
		if (state_q == lpht_pkg::S_HASH && !rem_busy) begin
			idx_q   <= rem_idx;
			probe_q <= '0;
		end else if (ctl.advance) begin
			idx_q   <= idx_next;
			probe_q <= probe_q + 1'b1;
		end
		if (ctl.finish) begin
			res_q.status      <= ctl.status;
			res_q.found_value <= ctl.use_value ? lpht_pkg::FOUND_W'(val_rd) : '0;
			res_q.live_count  <= lpht_pkg::LIVE_W'(count_d);
		end
	end

	assign busy   = (state_q != lpht_pkg::S_IDLE);
	assign done   = done_q;
	assign result = res_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !bad_op) |=> busy) else $error("accepted item did not start");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(DEPTH)) else $error("live count beyond depth");
	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lpht_pkg::S_CHECK) |-> (probe_q < n_q && 32'(idx_q) < 32'(n_q)))
		else $error("probe beyond table size");
`endif

endmodule

>>> test/linear_probe_hash_table_core_test.sv
// linear_probe_hash_table_core_test: self-checking bench for the hash table core
// depends on lpht_pkg and linear_probe_hash_table_core; predicts every result in-bench
`timescale 1ns / 100ps

module linear_probe_hash_table_core_test;

	localparam int SLOTS = 1024;
	localparam int STALL_LIMIT = 20000;

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	lpht_pkg::cmd_t cmd;
	logic           done;
	lpht_pkg::res_t result;
	logic           psel, penable, pwrite;
	logic [2:0]     paddr;
	logic [31:0]    pwdata;
	logic [31:0]    prdata;
	logic           pready;

	linear_probe_hash_table_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	// shadow copy of the table
	logic [1:0]  shadow_state [SLOTS];
	logic [63:0] shadow_key   [SLOTS];
	logic [31:0] shadow_value [SLOTS];
	int unsigned shadow_live;
	logic [10:0] shadow_size;

	lpht_pkg::res_t pending_results [$];
	int             fail_count;
	int             idle_cycles;
	bit             calm;
	logic [63:0]    used_keys [$];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int unsigned span();
		if (shadow_size == 0) return 1;
		if (shadow_size > SLOTS) return SLOTS;
		return 32'(shadow_size);
	endfunction

	function automatic int find_slot(logic [63:0] k);
		int unsigned n, idx;
		n = span();
		idx = 32'(k % n);
		for (int i = 0; i < n; i++) begin
			if (shadow_state[idx] == lpht_pkg::SLOT_OCC && shadow_key[idx] == k) return idx;
			idx = (idx + 1 >= n) ? 0 : idx + 1;
		end
		return -1;
	endfunction

	// work out the result of one command and update the shadow table
	function automatic lpht_pkg::res_t apply_command(lpht_pkg::cmd_t c);
		lpht_pkg::res_t r;
		int unsigned n, idx;
		int hit;
		n = span();
		r.status = lpht_pkg::ST_MISS;
		r.found_value = '0;
		if (c.op == lpht_pkg::OP_INSERT) begin
			idx = 32'(c.key % n);
			for (int i = 0; i < n; i++) begin
				if (shadow_state[idx] == lpht_pkg::SLOT_OCC) begin
					if (shadow_key[idx] == c.key) begin
						r.status = lpht_pkg::ST_DUP;
						break;
					end
				end else begin
					shadow_state[idx] = lpht_pkg::SLOT_OCC;
					shadow_key[idx] = c.key;
					shadow_value[idx] = c.value;
					shadow_live++;
					r.status = lpht_pkg::ST_OK;
					break;
				end
				idx = (idx + 1 >= n) ? 0 : idx + 1;
			end
		end else if (c.op == lpht_pkg::OP_FIND) begin
			hit = find_slot(c.key);
			if (hit >= 0) begin
				r.status = lpht_pkg::ST_OK;
				r.found_value = shadow_value[hit];
			end
		end else if (c.op == lpht_pkg::OP_ERASE) begin
			hit = find_slot(c.key);
			if (hit >= 0) begin
				shadow_state[hit] = lpht_pkg::SLOT_DEL;
				if (shadow_live > 0) shadow_live--;
				r.status = lpht_pkg::ST_OK;
			end
		end
		r.live_count = shadow_live[10:0];
		return r;
	endfunction

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		lpht_pkg::res_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result status=%0d", result.status);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.status !== want.status) begin
					$error("status: expected %0d actual %0d", want.status, result.status);
					fail_count++;
				end
				if (result.found_value !== want.found_value) begin
					$error("found_value: expected %0h actual %0h",
						want.found_value, result.found_value);
					fail_count++;
				end
				if (result.live_count !== want.live_count) begin
					$error("live_count: expected %0d actual %0d",
						want.live_count, result.live_count);
					fail_count++;
				end
			end
		end
	end

	// idle burst before a transfer; start drops only when a gap is taken
	task automatic random_gap();
		int g;
		if (!calm && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			g = $urandom_range(1, 10);
			repeat (g) @(posedge clk);
		end
	endtask

	// one command transfer; start stays high for a following command
	task automatic send_command(logic [1:0] op, logic [63:0] k, logic [31:0] v);
		lpht_pkg::cmd_t c;
		c.op = op;
		c.key = k;
		c.value = v;
		random_gap();
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(apply_command(c));
		if (op == lpht_pkg::OP_INSERT) used_keys.push_back(k);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		while (busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write over the config port, only while idle
	task automatic write_table_size(logic [10:0] sz);
		wait_drained();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {lpht_pkg::REG_TABLE_SIZE, 2'b00};
		pwdata <= {21'd0, sz};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		shadow_size = sz;
		@(posedge clk);
		if (prdata[10:0] !== sz) begin
			$error("table_size: expected %0d actual %0d", sz, prdata[10:0]);
			fail_count++;
		end
	endtask

	function automatic logic [63:0] pick_key(int unsigned n);
		if (used_keys.size() != 0 && $urandom_range(0, 1))
			return used_keys[$urandom_range(0, used_keys.size() - 1)];
		if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
		return 64'($urandom_range(0, 3 * n));
	endfunction

	task automatic test_extremes();
		write_table_size(11'd8);
		send_command(lpht_pkg::OP_FIND, 64'd3, 32'd0);
		send_command(lpht_pkg::OP_ERASE, 64'd3, 32'd0);
		send_command(lpht_pkg::OP_INSERT, 64'd0, 32'd0);
		send_command(lpht_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send_command(lpht_pkg::OP_INSERT, 64'd8, 32'h1234_5678);
		send_command(lpht_pkg::OP_INSERT, 64'd0, 32'hAAAA_AAAA);
		send_command(lpht_pkg::OP_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
		send_command(lpht_pkg::OP_FIND, 64'd8, 32'd0);
		send_command(lpht_pkg::OP_ERASE, 64'd0, 32'd0);
		send_command(lpht_pkg::OP_FIND, 64'd8, 32'd0);
		send_command(lpht_pkg::OP_INSERT, 64'd16, 32'h5555_5555);
		send_command(lpht_pkg::OP_FIND, 64'd0, 32'd0);
		send_command(2'd3, 64'd8, 32'd1);
	endtask

	// fill a small table to overflow, then shrink with live entries
	task automatic test_full_and_resize();
		write_table_size(11'd4);
		for (int i = 0; i < 6; i++) send_command(lpht_pkg::OP_INSERT, 64'(i * 5 + 1), $urandom);
		send_command(lpht_pkg::OP_FIND, 64'd11, 32'd0);
		write_table_size(11'd1);
		send_command(lpht_pkg::OP_INSERT, 64'd7, 32'd9);
		send_command(lpht_pkg::OP_FIND, 64'd11, 32'd0);
		write_table_size(11'd0);
		send_command(lpht_pkg::OP_FIND, 64'd99, 32'd0);
		write_table_size(11'd2047);
		send_command(lpht_pkg::OP_FIND, 64'd11, 32'd0);
		send_command(lpht_pkg::OP_INSERT, 64'd2000, 32'd3);
	endtask

	task automatic test_random(int count, logic [10:0] sz);
		int unsigned n;
		logic [1:0] op;
		write_table_size(sz);
		used_keys.delete();
		n = span();
		for (int i = 0; i < count; i++) begin
			op = ($urandom_range(0, 30) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
			send_command(op, pick_key(n), $urandom);
		end
	endtask

	task automatic test_pause_until_drained();
		wait_drained();
		send_command(lpht_pkg::OP_FIND, 64'd0, 32'd0);
	endtask

	initial begin
		fail_count = 0;
		idle_cycles = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		for (int i = 0; i < SLOTS; i++) shadow_state[i] = lpht_pkg::SLOT_FREE;
		shadow_live = 0;
		shadow_size = 11'd1024;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);

		test_extremes();
		test_full_and_resize();
		test_random(250, 11'd16);
		test_pause_until_drained();
		test_random(300, 11'd7);
		test_random(150, 11'd64);
		test_random(100, 11'd1024);
		calm = 1'b1;
		test_random(200, 11'd5);

		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> sim.f
rtl/lpht_pkg.sv
rtl/lpht_ram.sv
rtl/lpht_rem.sv
rtl/linear_probe_hash_table_core.sv
test/linear_probe_hash_table_core_test.sv
